FILE: rtl/circular_fifo_queue_core_assert.svh
// ----------------------------------------------------------------------------
// circular fifo queue assertion macros
// property forms for the queue core, used by the datapath
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_CORE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_CORE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define CFQ_ASSERT_HOLDS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("cfq invariant violated");

// consequent holds in the cycle after the antecedent
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfq sequence violated");

`endif

FILE: rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// shared types, codes and defaults of the circular fifo queue core
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int CAP_W          = 5;
	localparam int REG_W          = 32;
	localparam int ADDR_W         = 3;

	// register select bit of paddr, word index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_SHOW = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_RESP = 2'd2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    enq;
		logic    deq;
		logic    show;
		logic    load_stat;
		status_t stat;
		logic    load_rd;
		logic    step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic out_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/circular_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_core: ring-buffer fifo with enqueue, dequeue and show
// enqueue and refusals: result valid in the cycle after accept
// dequeue: accept, S_READ captures the registered ram read port, then the result in S_RESP
// show: per stored item, one ram read then one handoff per result
// one item at a time: next item accepted the cycle after its last result goes
// reset: queue empty, head and tail zero, capacity DEPTH, no ram clearing
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue_core #(
	parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// input item stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [cfq_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] in_value
	input  wire logic [1:0]                    s_tuser,   // [1:0] operation

	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [cfq_pkg::VALUE_W-1:0]   m_tdata,   // [31:0] out_value
	output logic      [1:0]                    m_tuser,   // [1:0] status
	output logic                               m_tlast,

	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cfq_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [cfq_pkg::REG_W-1:0]     pwdata,
	output logic      [cfq_pkg::REG_W-1:0]     prdata,
	output logic                               pready
);

	localparam int CW = $clog2(DEPTH + 1);

	// readback value of capacity after reset, clipped to the 5-bit capacity field
	localparam logic [cfq_pkg::CAP_W-1:0] CAP_RST =
		(DEPTH > 31) ? {cfq_pkg::CAP_W{1'b1}} : cfq_pkg::CAP_W'(DEPTH);

	logic [cfq_pkg::CAP_W-1:0] cap_raw_q;   // value as written
	logic [CW-1:0]             cap_eff_q;   // effective capacity, 1..DEPTH
	logic [CW-1:0]             cap_eff_d;
	logic [cfq_pkg::CAP_W-1:0] cap_wr;
	logic                      cfg_wr;

	cfq_pkg::cmd_t    cmd;
	cfq_pkg::sts_t    sts;
	cfq_pkg::status_t out_status;

	// apb: zero wait states, register selected by the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == cfq_pkg::REG_CAPACITY);
	assign prdata = (paddr[2] == cfq_pkg::REG_CAPACITY)
		? cfq_pkg::REG_W'(cap_raw_q) : '0;

	// zero acts as one slot, anything above DEPTH acts as DEPTH
	assign cap_wr = pwdata[cfq_pkg::CAP_W-1:0];
	always_comb begin
		if (cap_wr == '0) begin
			cap_eff_d = CW'(1);
		end else if (32'(cap_wr) > DEPTH) begin
			cap_eff_d = CW'(DEPTH);
		end else begin
			cap_eff_d = CW'(cap_wr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q <= CAP_RST;
			cap_eff_q <= CW'(DEPTH);
		end else if (cfg_wr) begin
			cap_raw_q <= cap_wr;
			cap_eff_q <= cap_eff_d;
		end
	end

	// controller sequences one item: accept, optional ram read, handoff (repeated per stored item on show)
	cfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (cfq_pkg::op_t'(s_tuser)),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath also drops the queue on a capacity write (re-creation)
	cfq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (cfg_wr),
		.cap_eff    (cap_eff_q),
		.in_value   (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_value  (m_tdata),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_status;

endmodule

`default_nettype wire

FILE: rtl/cfq_ram.sv
// ----------------------------------------------------------------------------
// cfq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ram #(
	parameter int WIDTH = cfq_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// controller fsm: takes one item, sequences ram reads and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire cfq_pkg::op_t  in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire cfq_pkg::sts_t sts,
	output cfq_pkg::cmd_t      cmd
);

	cfq_pkg::state_t state_q;
	cfq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			cfq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_op)
						cfq_pkg::OP_ENQ: begin
							if (sts.full) begin
								cmd.load_stat = 1'b1;
								cmd.stat      = cfq_pkg::STAT_FULL;
							end else begin
								cmd.enq = 1'b1;
							end
							state_d = cfq_pkg::S_RESP;
						end
						cfq_pkg::OP_DEQ: begin
							if (sts.empty) begin
								cmd.load_stat = 1'b1;
								cmd.stat      = cfq_pkg::STAT_EMPTY;
								state_d       = cfq_pkg::S_RESP;
							end else begin
								cmd.deq = 1'b1;
								state_d = cfq_pkg::S_READ;
							end
						end
						cfq_pkg::OP_SHOW: begin
							if (sts.empty) begin
								cmd.load_stat = 1'b1;
								cmd.stat      = cfq_pkg::STAT_EMPTY;
								state_d       = cfq_pkg::S_RESP;
							end else begin
								cmd.show = 1'b1;
								state_d  = cfq_pkg::S_READ;
							end
						end
						default: begin
							// unknown operation: plain ok, no queue change
							cmd.load_stat = 1'b1;
							cmd.stat      = cfq_pkg::STAT_OK;
							state_d       = cfq_pkg::S_RESP;
						end
					endcase
				end
			end
			cfq_pkg::S_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = cfq_pkg::S_RESP;
			end
			cfq_pkg::S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.out_last) begin
						state_d = cfq_pkg::S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = cfq_pkg::S_READ;
					end
				end
			end
			default: begin
				state_d = cfq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/cfq_datapath.sv
// ----------------------------------------------------------------------------
// cfq_datapath
// ring pointers, occupancy count, slot ram and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_datapath #(
	parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clr,
	input  wire logic [$clog2(DEPTH + 1)-1:0]  cap_eff,
	input  wire logic [cfq_pkg::VALUE_W-1:0]   in_value,
	input  wire cfq_pkg::cmd_t                 cmd,
	output cfq_pkg::sts_t                      sts,
	output logic      [cfq_pkg::VALUE_W-1:0]   out_value,
	output cfq_pkg::status_t                   out_status,
	output logic                               out_last
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;

	logic [cfq_pkg::VALUE_W-1:0] out_value_q;
	cfq_pkg::status_t            out_status_q;
	logic                        out_last_q;

	logic [IW-1:0]                raddr;
	logic [DATA_WIDTH-1:0]        wdata;
	logic [DATA_WIDTH-1:0]        rdata;
	logic signed [63:0]           in_ext;
	logic signed [DATA_WIDTH-1:0] rd_s;
	logic signed [63:0]           rd_ext;

	// step an index around the ring of cap slots
	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
	                                           input logic [CW-1:0] cap);
		logic [IW:0] inc;
		inc = {1'b0, idx} + {{IW{1'b0}}, 1'b1};
		if (32'(inc) >= 32'(cap)) begin
			return '0;
		end
		return inc[IW-1:0];
	endfunction

	assign in_ext = 64'(signed'(in_value));
	assign wdata  = in_ext[DATA_WIDTH-1:0];
	assign rd_s   = rdata;
	assign rd_ext = 64'(rd_s);

	// next show position on a step, else the head
	assign raddr = cmd.step ? wrap_inc(pos_q, cap_eff) : head_q;

	cfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.enq),
		.waddr (tail_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
			rem_q   <= '0;
		end else if (clr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.enq) begin
				tail_q  <= wrap_inc(tail_q, cap_eff);
				count_q <= count_q + CW'(1);
			end
			if (cmd.deq) begin
				head_q  <= wrap_inc(head_q, cap_eff);
				count_q <= count_q - CW'(1);
				rem_q   <= CW'(1);
			end
			if (cmd.show) begin
				pos_q <= head_q;
				rem_q <= count_q;
			end
			if (cmd.step) begin
				pos_q <= wrap_inc(pos_q, cap_eff);
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_status_q <= cfq_pkg::STAT_OK;
			out_last_q   <= 1'b1;
		end else if (cmd.enq) begin
			out_status_q <= cfq_pkg::STAT_OK;
			out_last_q   <= 1'b1;
		end else if (cmd.load_stat) begin
			out_status_q <= cmd.stat;
			out_last_q   <= 1'b1;
		end else if (cmd.load_rd) begin
			out_status_q <= cfq_pkg::STAT_OK;
			out_last_q   <= (rem_q == CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq || cmd.load_stat) begin
			out_value_q <= '0;
		end else if (cmd.load_rd) begin
			out_value_q <= rd_ext[cfq_pkg::VALUE_W-1:0];
		end
	end

	assign sts.full     = (count_q >= cap_eff);
	assign sts.empty    = (count_q == '0);
	assign sts.out_last = out_last_q;

	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	`include "circular_fifo_queue_core_assert.svh"

	`CFQ_ASSERT_HOLDS(a_count_le_cap, clk, arst_n, count_q <= cap_eff)
	`CFQ_ASSERT_HOLDS(a_head_in_ring, clk, arst_n, 32'(head_q) < 32'(cap_eff))
	`CFQ_ASSERT_HOLDS(a_tail_in_ring, clk, arst_n, 32'(tail_q) < 32'(cap_eff))
	`CFQ_ASSERT_NEXT(a_enq_counts, clk, arst_n, cmd.enq && !clr,
		count_q == $past(count_q) + CW'(1))

endmodule

`default_nettype wire
